[rtl/dntc_pkg.sv]
// Shared types, constants and widths for the decimal number to text cells block.
package dntc_pkg;

    // Field widths of the request and the cell write
    localparam int COLUMN_W = 6;
    localparam int ROW_W    = 5;
    localparam int VALUE_W  = 16;
    localparam int INK_W    = 4;
    localparam int OFFSET_W = 10;
    localparam int CODE_W   = 6;

    // Decimal conversion
    localparam int DIGITS  = 5;
    localparam int DIGIT_W = 4;
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int POS_W   = $clog2(DIGITS);
    localparam int STEP_W  = $clog2(VALUE_W);

    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;
    localparam logic [CODE_W-1:0]  CODE_ZERO  = 6'd48;

    // Defaults for the top-level parameters
    localparam int DEF_COLUMNS     = 40;
    localparam int DEF_QUEUE_DEPTH = 2;

    // One number to display
    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [VALUE_W-1:0]  value;
        logic [INK_W-1:0]    ink;
    } req_item_t;

    // One text cell write
    typedef struct packed {
        logic [OFFSET_W-1:0] cell_offset;
        logic [CODE_W-1:0]   screen_code;
        logic [INK_W-1:0]    cell_color;
        logic                last;
    } wr_item_t;

    // Converted number waiting for the cell writer
    typedef struct packed {
        logic [BCD_W-1:0]    digits;
        logic [POS_W-1:0]    top_pos;
        logic [OFFSET_W-1:0] base;
        logic [INK_W-1:0]    ink;
    } job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_CONV,
        FRONT_PUSH
    } front_state_t;

endpackage

[rtl/dntc_front.sv]
// Front end: takes a request, converts the value to decimal digits by shift-add-3.
module dntc_front
    import dntc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  req_item_t    req,
    output logic         push,
    output job_t         push_job,
    input  queue_flags_t flags
);

    front_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [OFFSET_W-1:0]   base_reg, base_next;
    logic [INK_W-1:0]      ink_reg, ink_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [POS_W-1:0]      top_pos;
    logic                  accept;

    assign req_stall = (state_reg != FRONT_IDLE);
    assign accept    = req_valid && !req_stall;

    // Add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT)
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Find the leading nonzero digit; zero still shows one digit
    always_comb
    begin
        top_pos = '0;
        for (int i = 1; i < DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_pos = POS_W'(i);
            end
        end
    end

    assign push_job.digits  = bcd_reg;
    assign push_job.top_pos = top_pos;
    assign push_job.base    = base_reg;
    assign push_job.ink     = ink_reg;

    // Next state and datapath
    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        base_next  = base_reg;
        ink_next   = ink_reg;
        push       = 1'b0;
        case (state_reg)
            FRONT_IDLE:
            begin
                if (accept)
                begin
                    bin_next   = req.value;
                    bcd_next   = '0;
                    step_next  = '0;
                    base_next  = OFFSET_W'(req.row) * OFFSET_W'(COLUMNS)
                               + OFFSET_W'(req.column);
                    ink_next   = req.ink;
                    state_next = FRONT_CONV;
                end
            end
            FRONT_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(VALUE_W - 1))
                begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH:
            begin
                push = 1'b1;
                if (!flags.full)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the conversion datapath
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        step_reg <= step_next;
        base_reg <= base_next;
        ink_reg  <= ink_next;
    end

    // Every digit stays decimal while a number is in work
    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != FRONT_IDLE) |->
            (bcd_reg[3:0] <= DIGIT_MAX) && (bcd_reg[7:4] <= DIGIT_MAX) &&
            (bcd_reg[11:8] <= DIGIT_MAX) && (bcd_reg[15:12] <= DIGIT_MAX) &&
            (bcd_reg[19:16] <= DIGIT_MAX))
        else $error("front: digit out of decimal range");

    // A conversion ends in the push state after the last shift
    a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FRONT_CONV && step_reg == STEP_W'(VALUE_W - 1)) |=>
            (state_reg == FRONT_PUSH))
        else $error("front: conversion did not end in push");

endmodule

[rtl/dntc_queue.sv]
// Short queue of converted numbers between the front end and the cell writer.
module dntc_queue
    import dntc_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  job_t         push_job,
    input  logic         pop,
    output job_t         head,
    output queue_flags_t flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign flags.full  = (count_reg == CNT_W'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head        = entries_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Fill level never passes the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue: count beyond depth");

endmodule

[rtl/dntc_back.sv]
// Cell writer: emits one cell write per digit, leading digit first.
module dntc_back
    import dntc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  job_t         head,
    input  queue_flags_t flags,
    output logic         pop,
    output logic         wr_valid,
    input  logic         wr_stall,
    output wr_item_t     wr
);

    logic                busy_reg, busy_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [BCD_W-1:0]    digits_reg, digits_next;
    logic [INK_W-1:0]    ink_reg, ink_next;
    logic                out_valid_reg, out_valid_next;
    wr_item_t            out_reg, out_next;
    logic [DIGIT_W-1:0]  digit;
    logic                load_out;

    assign wr_valid = out_valid_reg;
    assign wr       = out_reg;
    assign pop      = !busy_reg && !flags.empty;
    assign load_out = busy_reg && (!out_valid_reg || !wr_stall);
    assign digit    = digits_reg[pos_reg*DIGIT_W +: DIGIT_W];

    // Pick up a job, then step through its digits
    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        off_next       = off_reg;
        digits_next    = digits_reg;
        ink_next       = ink_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            busy_next   = 1'b1;
            pos_next    = head.top_pos;
            off_next    = head.base;
            digits_next = head.digits;
            ink_next    = head.ink;
        end
        if (load_out)
        begin
            out_next.cell_offset = off_reg;
            out_next.screen_code = CODE_ZERO + CODE_W'(digit);
            out_next.cell_color  = ink_reg;
            out_next.last        = (pos_reg == '0);
            out_valid_next       = 1'b1;
            pos_next             = pos_reg - 1'b1;
            off_next             = off_reg + 1'b1;
            if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_valid_reg && !wr_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold job and output payload
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        off_reg    <= off_next;
        digits_reg <= digits_next;
        ink_reg    <= ink_next;
        out_reg    <= out_next;
    end

    // Only digit characters leave the block
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_reg.screen_code >= CODE_ZERO) &&
            (out_reg.screen_code <= CODE_ZERO + CODE_W'(DIGIT_MAX)))
        else $error("back: screen code is not a digit");

    // Digit position stays within the number
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= POS_W'(DIGITS - 1)))
        else $error("back: digit position out of range");

endmodule

[rtl/decimal_number_to_text_cells_core.sv]
// Top level of the decimal number to text cells block.
// Each request (column, row, value, ink) becomes one to five text cell writes, leading digit
// first with leading zeros dropped (zero shows a single '0'), at offsets row*COLUMNS+column+k
// modulo 1024; the final digit carries last. The front end takes a request, converts the
// value by 16 shift-add-3 steps and hands it to a QUEUE_DEPTH-entry queue; it stalls new
// requests until that number is pushed, which waits while the queue is full. The cell writer
// takes a queued number and then issues one write per cycle while the write side is not
// stalled, overlapping the next conversion; the sustained rate of numbers is set by the
// conversion loop, while the write side is not stalled.
module decimal_number_to_text_cells_core
    import dntc_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      wr_valid,
    input  logic      wr_stall,
    output wr_item_t  wr
);

    logic         push;
    logic         pop;
    job_t         push_job;
    job_t         head;
    queue_flags_t flags;

    dntc_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_job  (push_job),
        .flags     (flags)
    );

    dntc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .flags    (flags)
    );

    dntc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .flags    (flags),
        .pop      (pop),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr       (wr)
    );

endmodule

[dv/decimal_number_to_text_cells_core_test.sv]
// Self-checking testbench for the decimal number to text cells core.
module decimal_number_to_text_cells_core_test
    import dntc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_COUNT = 63;
    localparam int SETTLE_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      wr_valid;
    logic      wr_stall = 1'b0;
    wr_item_t  wr;

    req_item_t pending_reqs[$];
    wr_item_t  expected_writes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int numbers_sent = 0;
    int writes_checked = 0;
    int wrapped_numbers = 0;
    int cycle_count = 0;

    decimal_number_to_text_cells_core #(
        .COLUMNS (COLUMNS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .wr_valid  (wr_valid),
        .wr_stall  (wr_stall),
        .wr        (wr)
    );

    // Free-running 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Split a number into its decimal cell writes and queue them
    function automatic void predict_cell_writes(input req_item_t r);
        int unsigned remaining;
        int unsigned digit_vals[DIGITS];
        int unsigned base;
        int          n;
        int          k;
        wr_item_t    w;
        remaining = r.value;
        n = 0;
        if (remaining == 0)
        begin
            digit_vals[0] = 0;
            n = 1;
        end
        else
        begin
            while (remaining > 0 && n < DIGITS)
            begin
                digit_vals[n] = remaining % 10;
                remaining = remaining / 10;
                n++;
            end
        end
        base = r.row * COLUMNS + r.column;
        if (base + n - 1 >= 1024)
            wrapped_numbers++;
        for (k = 0; k < n; k++)
        begin
            w.cell_offset = OFFSET_W'(base + k);
            w.screen_code = CODE_ZERO + CODE_W'(digit_vals[n - 1 - k]);
            w.cell_color  = r.ink;
            w.last        = (k == n - 1);
            expected_writes.push_back(w);
        end
    endfunction

    function automatic req_item_t make_req(input int col, input int rw, input int val,
                                           input int color);
        req_item_t r;
        r.column = COLUMN_W'(col);
        r.row    = ROW_W'(rw);
        r.value  = VALUE_W'(val);
        r.ink    = INK_W'(color);
        return r;
    endfunction

    // Mostly on-screen positions, spread over all digit counts
    function automatic req_item_t random_req();
        req_item_t r;
        int        val;
        case ($urandom_range(0, 7))
            0: val = $urandom_range(0, 9);
            1: val = $urandom_range(10, 99);
            2: val = $urandom_range(100, 999);
            3: val = $urandom_range(1000, 9999);
            4: val = $urandom_range(10000, 65535);
            5: val = ($urandom_range(0, 3) == 0) ? 0 : 65535;
            default: val = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 9) == 0)
            r = make_req($urandom_range(0, 63), $urandom_range(0, 31), val,
                         $urandom_range(0, 15));
        else
            r = make_req($urandom_range(0, 39), $urandom_range(0, 24), val,
                         $urandom_range(0, 15));
        return r;
    endfunction

    // Driver: hold a stalled transfer, otherwise present the next number or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!(req_valid && req_stall))
        begin
            if (req_valid)
            begin
                predict_cell_writes(req);
                numbers_sent++;
            end
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted cell write against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_stall <= 1'b0;
        end
        else
        begin
            if (wr_valid && !wr_stall)
            begin
                if (expected_writes.size() == 0)
                begin
                    $display("%0t: unexpected cell write", $time,
                             " offset=%0d code=%0d color=%0d last=%0d",
                             wr.cell_offset, wr.screen_code, wr.cell_color, wr.last);
                    mismatch_count++;
                end
                else
                begin
                    wr_item_t exp_w;
                    exp_w = expected_writes.pop_front();
                    if (wr.cell_offset !== exp_w.cell_offset
                        || wr.screen_code !== exp_w.screen_code
                        || wr.cell_color !== exp_w.cell_color
                        || wr.last !== exp_w.last)
                    begin
                        $display("%0t: cell write mismatch: expected offset=%0d code=%0d",
                                 $time, exp_w.cell_offset, exp_w.screen_code,
                                 " color=%0d last=%0d,", exp_w.cell_color, exp_w.last,
                                 " got offset=%0d code=%0d color=%0d last=%0d",
                                 wr.cell_offset, wr.screen_code, wr.cell_color, wr.last);
                        mismatch_count++;
                    end
                    writes_checked++;
                end
            end
            wr_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d writes outstanding", $time,
                     expected_writes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus phases
    initial
    begin
        int phase;
        int i;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase

            if (phase == 0)
            begin
                // Zero, digit-count boundaries, extremes and wrapped offsets
                pending_reqs.push_back(make_req(0, 0, 0, 0));
                pending_reqs.push_back(make_req(39, 24, 65535, 15));
                pending_reqs.push_back(make_req(5, 3, 1, 1));
                pending_reqs.push_back(make_req(10, 7, 9, 2));
                pending_reqs.push_back(make_req(20, 11, 10, 4));
                pending_reqs.push_back(make_req(33, 19, 99, 8));
                pending_reqs.push_back(make_req(1, 1, 100, 3));
                pending_reqs.push_back(make_req(2, 2, 999, 5));
                pending_reqs.push_back(make_req(3, 4, 1000, 6));
                pending_reqs.push_back(make_req(16, 8, 9999, 7));
                pending_reqs.push_back(make_req(24, 16, 10000, 9));
                pending_reqs.push_back(make_req(35, 23, 10001, 10));
                pending_reqs.push_back(make_req(21, 10, 16'hAAAA, 11));
                pending_reqs.push_back(make_req(42, 21, 16'h5555, 12));
                pending_reqs.push_back(make_req(0, 24, 50505, 13));
                pending_reqs.push_back(make_req(39, 0, 0, 14));
                pending_reqs.push_back(make_req(63, 31, 65535, 15));
                pending_reqs.push_back(make_req(63, 31, 0, 0));
                pending_reqs.push_back(make_req(31, 25, 12345, 5));
                pending_reqs.push_back(make_req(12, 30, 8, 10));
            end
            for (i = 0; i < RANDOM_COUNT; i++)
                pending_reqs.push_back(random_req());

            // Pause the sender until every cell write of this phase has arrived
            while (pending_reqs.size() > 0 || req_valid || expected_writes.size() > 0)
                @(negedge clk);
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d numbers (%0d with wrapped offsets), checked %0d cell writes",
                 numbers_sent, wrapped_numbers, writes_checked);
        $display("over four handshake phases: free flow, idle sender, stalling receiver, both");
        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
